>>> rtl/bfa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types, codes and helpers of the best-fit block allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

   localparam int LEN_BITS = 16;
   localparam int CSR_INDEX_BITS = 8;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_INIT  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NOFIT   = 2'd1,
      ST_UNKNOWN = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_POOL_BASE   = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_POOL_LENGTH = 8'd1;

   localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

   function automatic logic [LEN_BITS-1:0] sat_add(input logic [LEN_BITS-1:0] a,
                                                   input logic [LEN_BITS-1:0] b);
      logic [LEN_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[LEN_BITS] ? LEN_MAX : s[LEN_BITS-1:0];
   endfunction

endpackage

>>> rtl/bfa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/best_fit_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_block_allocator
// Best-fit allocator over a word-address pool with free and used tables.
// ----------------------------------------------------------------------------
// allocate: one sweep over both tables in S_ASCAN, then S_ACOMMIT writes the result
// free: S_USCAN, S_FSCAN, then S_FCOMMIT; an unknown block answers after S_USCAN
// init, unused operation and zero-size allocate: result in the cycle after start
// next start is taken in the result cycle; one transaction at a time, none while busy
// the result strobe is never stalled
// after reset the block is busy for one cycle while it loads pool entry zero
module best_fit_block_allocator #(
   parameter int FREE_SLOTS = 32,
   parameter int USED_SLOTS = 64,
   parameter int ADDR_BITS  = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_operation,
   input  logic [15:0]                        req_request_size,
   input  logic [15:0]                        req_block_addr,
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_status,
   output logic [15:0]                        rsp_granted_addr,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bfa_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [15:0]                        csr_data
);

   import bfa_pkg::*;

   localparam int AW = ADDR_BITS;
   localparam int LW = LEN_BITS;
   localparam int SW = AW + LW;
   localparam int EW = AW + LW;
   localparam int FW = $clog2(FREE_SLOTS);
   localparam int UW = $clog2(USED_SLOTS);
   localparam int SCAN_MAX = (FREE_SLOTS > USED_SLOTS) ? FREE_SLOTS : USED_SLOTS;
   localparam int CW = $clog2(SCAN_MAX + 1);

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_INIT    = 7'b0000010,
      S_ASCAN   = 7'b0000100,
      S_ACOMMIT = 7'b0001000,
      S_USCAN   = 7'b0010000,
      S_FSCAN   = 7'b0100000,
      S_FCOMMIT = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [FREE_SLOTS-1:0] free_valid_ff, free_valid_in;
   logic [USED_SLOTS-1:0] used_valid_ff, used_valid_in;
   logic [15:0] pool_base_ff, pool_base_in, pool_length_ff, pool_length_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic [15:0] rsp_granted_ff, rsp_granted_in;

   logic best_found_ff, best_found_in, slot_found_ff, slot_found_in;
   logic u_found_ff, u_found_in, prev_found_ff, prev_found_in;
   logic next_found_ff, next_found_in, empty_found_ff, empty_found_in;

   logic [LW-1:0] size_ff, size_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [FW-1:0] best_idx_ff, best_idx_in;
   logic [AW-1:0] best_start_ff, best_start_in;
   logic [LW-1:0] best_len_ff, best_len_in;
   logic [UW-1:0] slot_idx_ff, slot_idx_in, u_idx_ff, u_idx_in;
   logic [LW-1:0] u_len_ff, u_len_in;
   logic [AW-1:0] end_ff, end_in;
   logic [FW-1:0] prev_idx_ff, prev_idx_in, next_idx_ff, next_idx_in;
   logic [FW-1:0] empty_idx_ff, empty_idx_in;
   logic [AW-1:0] prev_start_ff, prev_start_in;
   logic [LW-1:0] prev_len_ff, prev_len_in, next_len_ff, next_len_in;

   logic fr_we, ur_we;
   logic [FW-1:0] fr_waddr;
   logic [UW-1:0] ur_waddr;
   logic [EW-1:0] fr_wdata, fr_rdata, ur_wdata, ur_rdata;
   logic [AW-1:0] fr_start, ur_start;
   logic [LW-1:0] fr_len, ur_len, merged_len;
   logic [CW-1:0] prev_cnt;
   logic [FW-1:0] pf_idx;
   logic [UW-1:0] pu_idx;
   logic accept, pf_ok, pu_ok, next_eff;
   logic [SW-1:0] sum_wide;

   bfa_ram #(.WIDTH(EW), .DEPTH(FREE_SLOTS)) u_free_ram (
      .clock   (clock),
      .wr_en   (fr_we),
      .wr_addr (fr_waddr),
      .wr_data (fr_wdata),
      .rd_addr (cnt_ff[FW-1:0]),
      .rd_data (fr_rdata)
   );

   bfa_ram #(.WIDTH(EW), .DEPTH(USED_SLOTS)) u_used_ram (
      .clock   (clock),
      .wr_en   (ur_we),
      .wr_addr (ur_waddr),
      .wr_data (ur_wdata),
      .rd_addr (cnt_ff[UW-1:0]),
      .rd_data (ur_rdata)
   );

   assign fr_start = fr_rdata[EW-1:LW];
   assign fr_len   = fr_rdata[LW-1:0];
   assign ur_start = ur_rdata[EW-1:LW];
   assign ur_len   = ur_rdata[LW-1:0];

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = !busy;
   assign accept    = start && !busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_granted_addr = rsp_granted_ff;

   // read data is registered, so it belongs to the previous count value
   assign prev_cnt = cnt_ff - 1'b1;
   assign pf_idx   = prev_cnt[FW-1:0];
   assign pu_idx   = prev_cnt[UW-1:0];
   assign pf_ok    = (cnt_ff != '0) && (prev_cnt < CW'(FREE_SLOTS));
   assign pu_ok    = (cnt_ff != '0) && (prev_cnt < CW'(USED_SLOTS));
   assign sum_wide = SW'(fr_start) + SW'(fr_len);
   assign next_eff = next_found_ff && !(prev_found_ff && (next_idx_ff == prev_idx_ff));

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      free_valid_in = free_valid_ff;
      used_valid_in = used_valid_ff;
      pool_base_in = pool_base_ff;
      pool_length_in = pool_length_ff;
      rsp_valid_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_granted_in = rsp_granted_ff;
      best_found_in = best_found_ff;
      slot_found_in = slot_found_ff;
      u_found_in = u_found_ff;
      prev_found_in = prev_found_ff;
      next_found_in = next_found_ff;
      empty_found_in = empty_found_ff;
      size_in = size_ff;
      addr_in = addr_ff;
      best_idx_in = best_idx_ff;
      best_start_in = best_start_ff;
      best_len_in = best_len_ff;
      slot_idx_in = slot_idx_ff;
      u_idx_in = u_idx_ff;
      u_len_in = u_len_ff;
      end_in = end_ff;
      prev_idx_in = prev_idx_ff;
      next_idx_in = next_idx_ff;
      empty_idx_in = empty_idx_ff;
      prev_start_in = prev_start_ff;
      prev_len_in = prev_len_ff;
      next_len_in = next_len_ff;
      fr_we = 1'b0;
      fr_waddr = '0;
      fr_wdata = {AW'(pool_base_ff), pool_length_ff};
      ur_we = 1'b0;
      ur_waddr = slot_idx_ff;
      ur_wdata = {best_start_ff, size_ff};
      merged_len = sat_add(prev_len_ff, u_len_ff);

      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_POOL_BASE) begin
            pool_base_in = csr_data;
         end else if (csr_index == CSR_POOL_LENGTH) begin
            pool_length_in = csr_data;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               size_in = req_request_size;
               addr_in = AW'(req_block_addr);
               cnt_in = '0;
               best_found_in = 1'b0;
               slot_found_in = 1'b0;
               u_found_in = 1'b0;
               prev_found_in = 1'b0;
               next_found_in = 1'b0;
               empty_found_in = 1'b0;
               rsp_status_in = ST_OK;
               rsp_granted_in = '0;
               case (op_type'(req_operation))
                  OP_ALLOC: begin
                     if (req_request_size == '0) begin
                        rsp_status_in = ST_NOFIT;
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = S_ASCAN;
                     end
                  end
                  OP_FREE: state_in = S_USCAN;
                  OP_INIT: begin
                     free_valid_in = '0;
                     free_valid_in[0] = (pool_length_ff != '0);
                     used_valid_in = '0;
                     fr_we = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end
         S_INIT: begin
            free_valid_in = '0;
            free_valid_in[0] = (pool_length_ff != '0);
            used_valid_in = '0;
            fr_we = 1'b1;
            state_in = S_IDLE;
         end
         S_ASCAN: begin
            if (pf_ok && free_valid_ff[pf_idx] && (fr_len >= size_ff)) begin
               if (!best_found_ff || (fr_len < best_len_ff) ||
                   ((fr_len == best_len_ff) && (fr_start < best_start_ff))) begin
                  best_found_in = 1'b1;
                  best_idx_in = pf_idx;
                  best_start_in = fr_start;
                  best_len_in = fr_len;
               end
            end
            if ((cnt_ff < CW'(USED_SLOTS)) && !slot_found_ff &&
                !used_valid_ff[cnt_ff[UW-1:0]]) begin
               slot_found_in = 1'b1;
               slot_idx_in = cnt_ff[UW-1:0];
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(SCAN_MAX)) begin
               state_in = S_ACOMMIT;
            end
         end
         S_ACOMMIT: begin
            state_in = S_IDLE;
            rsp_valid_in = 1'b1;
            if (!best_found_ff) begin
               rsp_status_in = ST_NOFIT;
            end else if (!slot_found_ff) begin
               rsp_status_in = ST_FULL;
            end else begin
               rsp_granted_in = 16'(best_start_ff);
               ur_we = 1'b1;
               used_valid_in[slot_idx_ff] = 1'b1;
               if (best_len_ff > size_ff) begin
                  fr_we = 1'b1;
                  fr_waddr = best_idx_ff;
                  fr_wdata = {AW'(SW'(best_start_ff) + SW'(size_ff)), best_len_ff - size_ff};
               end else begin
                  free_valid_in[best_idx_ff] = 1'b0;
               end
            end
         end
         S_USCAN: begin
            if (pu_ok && !u_found_ff && used_valid_ff[pu_idx] && (ur_start == addr_ff)) begin
               u_found_in = 1'b1;
               u_idx_in = pu_idx;
               u_len_in = ur_len;
               end_in = AW'(SW'(addr_ff) + SW'(ur_len));
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(USED_SLOTS)) begin
               cnt_in = '0;
               if (u_found_in) begin
                  state_in = S_FSCAN;
               end else begin
                  state_in = S_IDLE;
                  rsp_status_in = ST_UNKNOWN;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         S_FSCAN: begin
            if (pf_ok) begin
               if (!free_valid_ff[pf_idx]) begin
                  if (!empty_found_ff) begin
                     empty_found_in = 1'b1;
                     empty_idx_in = pf_idx;
                  end
               end else begin
                  if (!prev_found_ff && (sum_wide[AW-1:0] == addr_ff)) begin
                     prev_found_in = 1'b1;
                     prev_idx_in = pf_idx;
                     prev_start_in = fr_start;
                     prev_len_in = fr_len;
                  end
                  if (!next_found_ff && (fr_start == end_ff)) begin
                     next_found_in = 1'b1;
                     next_idx_in = pf_idx;
                     next_len_in = fr_len;
                  end
               end
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(FREE_SLOTS)) begin
               state_in = S_FCOMMIT;
            end
         end
         S_FCOMMIT: begin
            state_in = S_IDLE;
            rsp_valid_in = 1'b1;
            if (!prev_found_ff && !next_eff && !empty_found_ff) begin
               rsp_status_in = ST_FULL;
            end else begin
               used_valid_in[u_idx_ff] = 1'b0;
               fr_we = 1'b1;
               if (prev_found_ff) begin
                  fr_waddr = prev_idx_ff;
                  if (next_eff) begin
                     merged_len = sat_add(sat_add(prev_len_ff, u_len_ff), next_len_ff);
                     free_valid_in[next_idx_ff] = 1'b0;
                  end
                  fr_wdata = {prev_start_ff, merged_len};
               end else if (next_eff) begin
                  fr_waddr = next_idx_ff;
                  fr_wdata = {addr_ff, sat_add(next_len_ff, u_len_ff)};
               end else begin
                  fr_waddr = empty_idx_ff;
                  fr_wdata = {addr_ff, u_len_ff};
                  free_valid_in[empty_idx_ff] = 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         cnt_ff <= '0;
         free_valid_ff <= '0;
         used_valid_ff <= '0;
         pool_base_ff <= '0;
         pool_length_ff <= 16'hFFFF;
         rsp_valid_ff <= 1'b0;
         best_found_ff <= 1'b0;
         slot_found_ff <= 1'b0;
         u_found_ff <= 1'b0;
         prev_found_ff <= 1'b0;
         next_found_ff <= 1'b0;
         empty_found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         free_valid_ff <= free_valid_in;
         used_valid_ff <= used_valid_in;
         pool_base_ff <= pool_base_in;
         pool_length_ff <= pool_length_in;
         rsp_valid_ff <= rsp_valid_in;
         best_found_ff <= best_found_in;
         slot_found_ff <= slot_found_in;
         u_found_ff <= u_found_in;
         prev_found_ff <= prev_found_in;
         next_found_ff <= next_found_in;
         empty_found_ff <= empty_found_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
      size_ff <= size_in;
      addr_ff <= addr_in;
      best_idx_ff <= best_idx_in;
      best_start_ff <= best_start_in;
      best_len_ff <= best_len_in;
      slot_idx_ff <= slot_idx_in;
      u_idx_ff <= u_idx_in;
      u_len_ff <= u_len_in;
      end_ff <= end_in;
      prev_idx_ff <= prev_idx_in;
      next_idx_ff <= next_idx_in;
      empty_idx_ff <= empty_idx_in;
      prev_start_ff <= prev_start_in;
      prev_len_ff <= prev_len_in;
      next_len_ff <= next_len_in;
   end

   // an accepted transaction either starts a sweep or answers at once
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy || rsp_valid))
      else $error("accepted transaction neither busy nor answered");

   // the chosen best fit is still a live free entry at commit
   a_best_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACOMMIT) && best_found_ff |-> free_valid_ff[best_idx_ff])
      else $error("best fit entry not valid at commit");

   // the freed block was found in a live used entry
   a_used_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FCOMMIT) |-> (u_found_ff && used_valid_ff[u_idx_ff]))
      else $error("free commit without a live used entry");

   a_granted_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> (rsp_granted_addr == '0))
      else $error("granted address nonzero on error status");

endmodule

>>> verif/best_fit_block_allocator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_block_allocator_checker
// Watches the request, result and register channels of the allocator. It
// keeps its own copy of the free and used tables, works out the status and
// the granted address of every accepted request, and compares each result
// with the oldest outstanding one.
// ----------------------------------------------------------------------------
module best_fit_block_allocator_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  logic [1:0]                         req_operation,
   input  logic [15:0]                        req_request_size,
   input  logic [15:0]                        req_block_addr,
   input  logic                               rsp_valid,
   input  logic [1:0]                         rsp_status,
   input  logic [15:0]                        rsp_granted_addr,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [bfa_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [15:0]                        csr_data,
   output int                                 fails,
   output int                                 pending
);

   import bfa_pkg::*;

   localparam int NFREE = 32;
   localparam int NUSED = 64;

   typedef struct packed {
      status_type  status;
      logic [15:0] granted;
   } grant_type;

   grant_type grant_q[$];

   logic [15:0] base_reg, length_reg;
   logic [15:0] free_addr [NFREE];
   logic [15:0] free_len  [NFREE];
   bit          free_live [NFREE];
   logic [15:0] used_addr [NUSED];
   logic [15:0] used_len  [NUSED];
   bit          used_live [NUSED];

   assign pending = grant_q.size();

   task automatic reload_pool();
      for (int i = 0; i < NFREE; i++) begin
         free_addr[i] = '0;
         free_len[i]  = '0;
         free_live[i] = 0;
      end
      for (int i = 0; i < NUSED; i++) begin
         used_addr[i] = '0;
         used_len[i]  = '0;
         used_live[i] = 0;
      end
      free_addr[0] = base_reg;
      free_len[0]  = length_reg;
      free_live[0] = (length_reg != 0);
   endtask

   function automatic logic [15:0] len_sat(logic [15:0] a, logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[16] ? 16'hFFFF : s[15:0];
   endfunction

   task automatic grant_block(input logic [15:0] size, output grant_type r);
      int best, slot;
      best = -1;
      slot = -1;
      r = '{status: ST_OK, granted: '0};
      if (size == 0) begin
         r.status = ST_NOFIT;
         return;
      end
      for (int i = 0; i < NFREE; i++) begin
         if (free_live[i] && free_len[i] >= size) begin
            if (best < 0 || free_len[i] < free_len[best] ||
                (free_len[i] == free_len[best] && free_addr[i] < free_addr[best]))
               best = i;
         end
      end
      if (best < 0) begin
         r.status = ST_NOFIT;
         return;
      end
      for (int i = 0; i < NUSED; i++) begin
         if (!used_live[i] && slot < 0) slot = i;
      end
      if (slot < 0) begin
         r.status = ST_FULL;
         return;
      end
      r.granted       = free_addr[best];
      used_live[slot] = 1;
      used_addr[slot] = free_addr[best];
      used_len[slot]  = size;
      if (free_len[best] > size) begin
         free_addr[best] = free_addr[best] + size;
         free_len[best]  = free_len[best] - size;
      end else begin
         free_live[best] = 0;
         free_addr[best] = '0;
         free_len[best]  = '0;
      end
   endtask

   task automatic release_block(input logic [15:0] addr, output grant_type r);
      int u, prev, next, empty;
      logic [15:0] len, stop, tail;
      u = -1;
      prev = -1;
      next = -1;
      empty = -1;
      r = '{status: ST_OK, granted: '0};
      for (int i = 0; i < NUSED; i++) begin
         if (u < 0 && used_live[i] && used_addr[i] == addr) u = i;
      end
      if (u < 0) begin
         r.status = ST_UNKNOWN;
         return;
      end
      len  = used_len[u];
      stop = addr + len;
      for (int i = 0; i < NFREE; i++) begin
         if (!free_live[i]) begin
            if (empty < 0) empty = i;
         end else begin
            tail = free_addr[i] + free_len[i];
            if (prev < 0 && tail == addr) prev = i;
            if (next < 0 && free_addr[i] == stop) next = i;
         end
      end
      // one entry touching both ends merges as the lower neighbor only
      if (prev >= 0 && next == prev) next = -1;
      if (prev < 0 && next < 0 && empty < 0) begin
         r.status = ST_FULL;
         return;
      end
      used_live[u] = 0;
      if (prev >= 0) begin
         free_len[prev] = len_sat(free_len[prev], len);
         if (next >= 0) begin
            free_len[prev]  = len_sat(free_len[prev], free_len[next]);
            free_live[next] = 0;
            free_addr[next] = '0;
            free_len[next]  = '0;
         end
      end else if (next >= 0) begin
         free_addr[next] = addr;
         free_len[next]  = len_sat(free_len[next], len);
      end else begin
         free_live[empty] = 1;
         free_addr[empty] = addr;
         free_len[empty]  = len;
      end
   endtask

   always @(posedge clock) begin
      grant_type r, exp_r;
      int errs;
      errs = 0;
      if (reset) begin
         base_reg   = '0;
         length_reg = 16'hFFFF;
         reload_pool();
         grant_q.delete();
         fails <= 0;
      end else begin
         if (rsp_valid) begin
            if (grant_q.size() == 0) begin
               $error("result with no outstanding transaction: status %0d addr %0h",
                      rsp_status, rsp_granted_addr);
               errs++;
            end else begin
               exp_r = grant_q.pop_front();
               if (rsp_status !== exp_r.status) begin
                  $error("status: expected %0d actual %0d", exp_r.status, rsp_status);
                  errs++;
               end
               if (rsp_granted_addr !== exp_r.granted) begin
                  $error("granted_addr: expected %0h actual %0h", exp_r.granted,
                         rsp_granted_addr);
                  errs++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_POOL_BASE) base_reg = csr_data;
            else if (csr_index == CSR_POOL_LENGTH) length_reg = csr_data;
         end
         if (start && !busy) begin
            r = '{status: ST_OK, granted: '0};
            case (op_type'(req_operation))
               OP_ALLOC: grant_block(req_request_size, r);
               OP_FREE:  release_block(req_block_addr, r);
               OP_INIT:  reload_pool();
               default:  ;
            endcase
            grant_q.push_back(r);
         end
         fails <= fails + errs;
      end
   end

endmodule

>>> verif/best_fit_block_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_block_allocator_tb
// Drives the allocator through directed corner cases and random phases of
// allocate and free traffic, with some init and unused operations, over several pool settings, with random gaps,
// and reports the checker's verdict.
// ----------------------------------------------------------------------------
module best_fit_block_allocator_tb;
   import bfa_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;

   logic                      clock = 0;
   logic                      reset = 1;
   logic                      start = 0;
   logic                      busy;
   logic [1:0]                req_operation = OP_NOP;
   logic [15:0]               req_request_size = '0;
   logic [15:0]               req_block_addr = '0;
   logic                      rsp_valid;
   logic [1:0]                rsp_status;
   logic [15:0]               rsp_granted_addr;
   logic                      csr_valid = 0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_POOL_BASE;
   logic [15:0]               csr_data = '0;
   int                        fails;
   int                        pending;
   int                        idle_cycles = 0;
   bit                        quiet_phase = 0;

   // ops in flight and the addresses currently held, for choosing frees
   op_type      op_q[$];
   logic [15:0] held_q[$];

   always #4 clock = ~clock;

   best_fit_block_allocator dut (.*);

   best_fit_block_allocator_checker checker_inst (.*);

   always @(posedge clock) begin
      op_type o;
      if (start && !busy) op_q.push_back(op_type'(req_operation));
      if (rsp_valid && op_q.size() > 0) begin
         o = op_q.pop_front();
         if (o == OP_INIT) held_q.delete();
         else if (o == OP_ALLOC && rsp_status == ST_OK) held_q.push_back(rsp_granted_addr);
      end
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("best_fit_block_allocator verification failed");
         $finish;
      end
   end

   function automatic int pick_gap();
      if (quiet_phase) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(0, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic send(input op_type op, input logic [15:0] size, input logic [15:0] addr);
      int gap;
      req_operation    <= op;
      req_request_size <= size;
      req_block_addr   <= addr;
      start            <= 1;
      @(posedge clock);
      while (busy) @(posedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx, input logic [15:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
   endtask

   task automatic settle();
      start <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic random_traffic(input int count, input int size_max);
      int sel, k;
      logic [15:0] size, addr;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(0, 99);
         if (sel < 50) begin
            size = (size_max > 0) ? 16'($urandom_range(1, size_max)) : 16'($urandom);
            if ($urandom_range(0, 19) == 0) size = 16'($urandom);
            if ($urandom_range(0, 29) == 0) size = '0;
            send(OP_ALLOC, size, 16'($urandom));
         end else if (sel < 92) begin
            if (held_q.size() > 0 && $urandom_range(0, 9) < 8) begin
               k = $urandom_range(0, held_q.size() - 1);
               addr = held_q[k];
               held_q.delete(k);
            end else begin
               addr = 16'($urandom);
            end
            send(OP_FREE, 16'($urandom), addr);
         end else if (sel < 96) begin
            send(OP_NOP, 16'($urandom), 16'($urandom));
         end else begin
            send(OP_INIT, 16'($urandom), 16'($urandom));
         end
      end
   endtask

   task automatic run_phase(input logic [15:0] base, input logic [15:0] len,
                            input int count, input int size_max);
      settle();
      write_reg(CSR_POOL_BASE, base);
      write_reg(CSR_POOL_LENGTH, len);
      quiet_phase = ($urandom_range(0, 3) == 0);
      send(OP_INIT, '0, '0);
      random_traffic(count, size_max);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed corners on the reset pool
      send(OP_ALLOC, 16'd0, 16'hFFFF);
      send(OP_ALLOC, 16'hFFFF, 16'd0);
      send(OP_ALLOC, 16'd1, 16'd0);
      send(OP_FREE, 16'd0, 16'd0);
      send(OP_FREE, 16'd0, 16'd0);
      send(OP_FREE, 16'hFFFF, 16'hFFFF);
      send(OP_NOP, 16'hFFFF, 16'hFFFF);
      send(OP_INIT, 16'hFFFF, 16'hFFFF);
      // split at address zero, then free in an order that merges both sides
      send(OP_ALLOC, 16'd10, 16'd0);
      send(OP_ALLOC, 16'd20, 16'd0);
      send(OP_ALLOC, 16'd30, 16'd0);
      send(OP_FREE, 16'd0, 16'd0);
      send(OP_FREE, 16'd0, 16'd30);
      send(OP_FREE, 16'd0, 16'd10);
      send(OP_ALLOC, 16'd65505, 16'd0);
      send(OP_ALLOC, 16'd60, 16'd0);
      send(OP_FREE, 16'd0, 16'd0);
      send(OP_FREE, 16'd0, 16'd60);

      // wrap at the top of the address space
      run_phase(16'hFFFF, 16'hFFFF, 120, 16);
      // empty pool and a one-word pool
      run_phase(16'h1234, 16'd0, 40, 4);
      run_phase(16'd0, 16'd1, 40, 2);
      // small pools fill both tables
      run_phase(16'($urandom), 16'd200, 300, 4);
      run_phase(16'hFFC0, 16'd400, 300, 8);
      run_phase(16'($urandom), 16'($urandom_range(100, 3000)), 300, 32);
      run_phase(16'd0, 16'hFFFF, 200, 0);
      run_phase(16'($urandom), 16'($urandom), 300, 64);

      settle();
      if (fails == 0 && pending == 0)
         $display("best_fit_block_allocator verification clean");
      else
         $display("best_fit_block_allocator verification failed");
      $finish;
   end

endmodule

>>> best_fit_block_allocator.f
rtl/bfa_pkg.sv
rtl/bfa_ram.sv
rtl/best_fit_block_allocator.sv
verif/best_fit_block_allocator_checker.sv
verif/best_fit_block_allocator_tb.sv
